@@ rtl/tsm_pkg.sv @@
// Shared types, codes and number-finishing functions for the time string parser.
package tsm_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [3:0] ERR_NONE           = 4'd0;
   localparam logic [3:0] ERR_HOUR_PARSE     = 4'd1;
   localparam logic [3:0] ERR_NO_COLON       = 4'd2;
   localparam logic [3:0] ERR_MINUTE_PARSE   = 4'd3;
   localparam logic [3:0] ERR_SECOND_PARSE   = 4'd4;
   localparam logic [3:0] ERR_NO_FRACTION    = 4'd5;
   localparam logic [3:0] ERR_FRACTION_PARSE = 4'd6;
   localparam logic [3:0] ERR_FRACTION_LONG  = 4'd7;
   localparam logic [3:0] ERR_TRAILING       = 4'd8;
   localparam logic [3:0] ERR_HOUR_RANGE     = 4'd9;
   localparam logic [3:0] ERR_MINUTE_RANGE   = 4'd10;
   localparam logic [3:0] ERR_SECOND_RANGE   = 4'd11;
   localparam logic [3:0] ERR_MILLIS_RANGE   = 4'd12;

   localparam logic [1:0] FLD_HOUR     = 2'd0;
   localparam logic [1:0] FLD_MINUTE   = 2'd1;
   localparam logic [1:0] FLD_SECOND   = 2'd2;
   localparam logic [1:0] FLD_FRACTION = 2'd3;

   localparam logic [31:0] HOUR_BOUND   = 32'd24;
   localparam logic [31:0] SIXTY_BOUND  = 32'd60;
   localparam logic [31:0] NEG_LIMIT    = 32'h8000_0000;
   localparam logic [26:0] DAY_MILLIS   = 27'd86_400_000;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_DIGIT,
      KIND_MINUS,
      KIND_COLON,
      KIND_DOT,
      KIND_OTHER
   } tsm_kind_type;

   typedef enum logic [1:0] {
      STEP_AWAIT,
      STEP_SIGN,
      STEP_DIGITS
   } tsm_step_type;

   typedef struct packed {
      tsm_kind_type kind;
      logic [3:0]   digit;
      logic         last;
   } tsm_item_type;

   typedef struct packed {
      logic [1:0]   field;
      tsm_step_type step;
      logic         negative;
      logic [31:0]  magnitude;
      logic         overflowed;
      logic [3:0]   digit_count;
      logic [4:0]   hour;
      logic [5:0]   minute;
      logic [5:0]   second;
      logic [9:0]   millis;
      logic [3:0]   faults;
      logic [3:0]   error;
   } tsm_parse_type;

   typedef struct packed {
      logic          valid;
      tsm_parse_type parse;
   } tsm_snap_type;

   typedef struct packed {
      logic [3:0] error;
      logic       fault;
      logic [9:0] value;
   } tsm_finish_type;

   localparam tsm_parse_type PARSE_RESET = '0;

   function automatic logic [3:0] parse_error(input logic [1:0] field);
      logic [3:0] code;
      unique case (field)
         FLD_HOUR:   code = ERR_HOUR_PARSE;
         FLD_MINUTE: code = ERR_MINUTE_PARSE;
         FLD_SECOND: code = ERR_SECOND_PARSE;
         default:    code = ERR_FRACTION_PARSE;
      endcase
      return code;
   endfunction

   // Close the current number: parse check, fraction scaling, range check.
   function automatic tsm_finish_type finish_number(input tsm_parse_type st);
      tsm_finish_type res;
      logic [4:0]     total;
      logic [16:0]    scaled;
      logic           too_big;
      res = '0;
      scaled = '0;
      too_big = st.negative ? (st.magnitude > NEG_LIMIT) : st.magnitude[31];
      total = {1'b0, st.digit_count} + {4'd0, st.negative};
      if (st.overflowed || too_big) begin
         res.error = parse_error(st.field);
      end else if (st.field == FLD_FRACTION) begin
         if (total > 5'd3) begin
            res.error = ERR_FRACTION_LONG;
         end else begin
            // at most three characters, so the magnitude is below 1000
            case (total)
               5'd1:    scaled = {7'd0, st.magnitude[9:0]} * 17'd100;
               5'd2:    scaled = {7'd0, st.magnitude[9:0]} * 17'd10;
               default: scaled = {7'd0, st.magnitude[9:0]};
            endcase
            res.fault = st.negative && (scaled != 17'd0);
            res.value = scaled[9:0];
         end
      end else begin
         res.fault = (st.negative && (st.magnitude != 32'd0)) ||
                     ((st.field == FLD_HOUR) ? (st.magnitude >= HOUR_BOUND)
                                             : (st.magnitude >= SIXTY_BOUND));
         res.value = st.magnitude[9:0];
      end
      return res;
   endfunction

   // Store a finished field or flag its range fault, then clear the number.
   function automatic tsm_parse_type apply_finish(input tsm_parse_type st,
                                                  input tsm_finish_type fin);
      tsm_parse_type res;
      res = st;
      if (fin.fault) begin
         res.faults[st.field] = 1'b1;
      end else begin
         case (st.field)
            FLD_HOUR:   res.hour   = fin.value[4:0];
            FLD_MINUTE: res.minute = fin.value[5:0];
            FLD_SECOND: res.second = fin.value[5:0];
            default:    res.millis = fin.value;
         endcase
      end
      res.negative    = 1'b0;
      res.magnitude   = '0;
      res.overflowed  = 1'b0;
      res.digit_count = '0;
      return res;
   endfunction

endpackage

@@ rtl/time_string_to_millis.sv @@
// Top level of the time-of-day string parser.
//
// The request channel takes one byte of an H:m[:s[.f]] string per word
// (req_character), with req_last on the final word and req_empty_req for a
// word that carries no byte. The response channel gives one word per string:
// rsp_error_code (0 ok, 1-8 format errors, 9-12 range errors) and
// rsp_millis_of_day (zero whenever the code is nonzero).
// A word is taken on a rising edge with valid high and stall low.
// Throughput: one request word per cycle, sustained, as long as responses are
// taken; the parse engine updates its state from each word that it pops.
// The response follows the last word through the queue, engine snapshot, end
// check, seconds sum and millisecond register.
// A request queue of QUEUE_DEPTH words decouples the byte classifier from the
// engine; req_stall rises only when that queue is full.
// When rsp_stall is held the finish pipeline fills, the engine then holds at
// the next last word, and the queue backs up into req_stall.
// Synchronous reset clears the queue, the parse state and all valid flags.
module time_string_to_millis #(
   parameter int QUEUE_DEPTH = tsm_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_last,
   input  logic        req_empty_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_error_code,
   output logic [26:0] rsp_millis_of_day
);

   tsm_pkg::tsm_item_type push_item;
   tsm_pkg::tsm_item_type head_item;
   tsm_pkg::tsm_snap_type snap;
   logic                  push_valid;
   logic                  queue_full;
   logic                  head_valid;
   logic                  pop;
   logic                  snap_stall;

   tsm_front u_front (
      .req_valid     (req_valid),
      .req_character (req_character),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push_valid    (push_valid),
      .push_item     (push_item)
   );

   tsm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   tsm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .snap       (snap),
      .snap_stall (snap_stall)
   );

   tsm_finish u_finish (
      .clock             (clock),
      .reset             (reset),
      .snap              (snap),
      .snap_stall        (snap_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_error_code    (rsp_error_code),
      .rsp_millis_of_day (rsp_millis_of_day)
   );

endmodule

@@ rtl/tsm_front.sv @@
// Input classifier: turns each request byte into a character-class word.
module tsm_front (
   input  logic                  req_valid,
   input  logic [7:0]            req_character,
   input  logic                  req_last,
   input  logic                  req_empty_req,
   input  logic                  queue_full,
   output logic                  req_stall,
   output logic                  push_valid,
   output tsm_pkg::tsm_item_type push_item
);

   always_comb begin
      push_item.digit = req_character[3:0];
      push_item.last  = req_last;
      if (req_empty_req) begin
         push_item.kind = tsm_pkg::KIND_NONE;
      end else if (req_character >= tsm_pkg::CHAR_ZERO &&
                   req_character <= tsm_pkg::CHAR_NINE) begin
         push_item.kind = tsm_pkg::KIND_DIGIT;
      end else if (req_character == tsm_pkg::CHAR_MINUS) begin
         push_item.kind = tsm_pkg::KIND_MINUS;
      end else if (req_character == tsm_pkg::CHAR_COLON) begin
         push_item.kind = tsm_pkg::KIND_COLON;
      end else if (req_character == tsm_pkg::CHAR_DOT) begin
         push_item.kind = tsm_pkg::KIND_DOT;
      end else begin
         push_item.kind = tsm_pkg::KIND_OTHER;
      end
   end

   assign push_valid = req_valid;
   assign req_stall  = queue_full;

endmodule

@@ rtl/tsm_queue.sv @@
// Short FIFO of classified words between the classifier and the parse engine.
module tsm_queue #(
   parameter int DEPTH = tsm_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  tsm_pkg::tsm_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output tsm_pkg::tsm_item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsm_pkg::tsm_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];
   assign push       = push_valid && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/tsm_engine.sv @@
// Parse engine: field/step machine, one word per cycle; a busy snap stalls a last word.
module tsm_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  tsm_pkg::tsm_item_type head_item,
   output logic                  pop,
   output tsm_pkg::tsm_snap_type snap,
   input  logic                  snap_stall
);

   tsm_pkg::tsm_parse_type  state_ff, state_in;
   tsm_pkg::tsm_parse_type  nxt;
   tsm_pkg::tsm_parse_type  snap_ff, snap_in;
   tsm_pkg::tsm_finish_type fin;
   logic                    snap_valid_ff, snap_valid_in;
   logic                    snap_free;
   logic [35:0]             prod;

   assign snap_free = !snap_valid_ff || !snap_stall;
   assign pop       = head_valid && (!head_item.last || snap_free);
   assign snap      = '{valid: snap_valid_ff, parse: snap_ff};

   always_comb begin
      nxt  = state_ff;
      fin  = tsm_pkg::finish_number(state_ff);
      prod = {1'b0, state_ff.magnitude, 3'b000} + {3'b000, state_ff.magnitude, 1'b0} +
             {32'd0, head_item.digit};
      if (head_item.kind != tsm_pkg::KIND_NONE && state_ff.error == tsm_pkg::ERR_NONE) begin
         if (head_item.kind == tsm_pkg::KIND_DIGIT) begin
            // saturate the magnitude once it passes 32 bits
            if (prod[35:32] != 4'd0) begin
               nxt.overflowed = 1'b1;
               nxt.magnitude  = '1;
            end else begin
               nxt.magnitude  = prod[31:0];
            end
            if (state_ff.digit_count != 4'hF) begin
               nxt.digit_count = state_ff.digit_count + 4'd1;
            end
            nxt.step = tsm_pkg::STEP_DIGITS;
         end else if (state_ff.step == tsm_pkg::STEP_AWAIT &&
                      head_item.kind == tsm_pkg::KIND_MINUS) begin
            nxt.negative = 1'b1;
            nxt.step     = tsm_pkg::STEP_SIGN;
         end else if (state_ff.step != tsm_pkg::STEP_DIGITS) begin
            nxt.error = tsm_pkg::parse_error(state_ff.field);
         end else if (fin.error != tsm_pkg::ERR_NONE) begin
            nxt.error = fin.error;
         end else begin
            nxt = tsm_pkg::apply_finish(state_ff, fin);
            case (state_ff.field)
               tsm_pkg::FLD_HOUR: begin
                  if (head_item.kind == tsm_pkg::KIND_COLON) begin
                     nxt.field = tsm_pkg::FLD_MINUTE;
                     nxt.step  = tsm_pkg::STEP_AWAIT;
                  end else begin
                     nxt.error = tsm_pkg::ERR_NO_COLON;
                  end
               end
               tsm_pkg::FLD_MINUTE: begin
                  if (head_item.kind == tsm_pkg::KIND_COLON) begin
                     nxt.field = tsm_pkg::FLD_SECOND;
                     nxt.step  = tsm_pkg::STEP_AWAIT;
                  end else begin
                     nxt.error = tsm_pkg::ERR_TRAILING;
                  end
               end
               tsm_pkg::FLD_SECOND: begin
                  if (head_item.kind == tsm_pkg::KIND_DOT) begin
                     nxt.field = tsm_pkg::FLD_FRACTION;
                     nxt.step  = tsm_pkg::STEP_AWAIT;
                  end else begin
                     nxt.error = tsm_pkg::ERR_TRAILING;
                  end
               end
               default: begin
                  nxt.error = tsm_pkg::ERR_TRAILING;
               end
            endcase
         end
      end

      state_in      = state_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_free ? 1'b0 : snap_valid_ff;
      if (pop) begin
         state_in = head_item.last ? tsm_pkg::PARSE_RESET : nxt;
         if (head_item.last) begin
            snap_in       = nxt;
            snap_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsm_pkg::PARSE_RESET;
         snap_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

`ifndef SYNTHESIS
   digits_hold_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.step != tsm_pkg::STEP_DIGITS |-> state_ff.digit_count == 4'd0)
      else $error("digit count nonzero outside a number");
   sign_sets_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff.step == tsm_pkg::STEP_SIGN |-> state_ff.negative)
      else $error("sign step without negative flag");
   error_sticks: assert property (@(posedge clock) disable iff (reset)
      (state_ff.error != tsm_pkg::ERR_NONE && !(pop && head_item.last))
      |=> state_ff.error != tsm_pkg::ERR_NONE)
      else $error("latched error dropped before string end");
   snap_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && snap_stall) |=> (snap_valid_ff && $stable(snap_ff)))
      else $error("snapshot lost while finish stage stalled");
`endif

endmodule

@@ rtl/tsm_finish.sv @@
// Finish pipeline: end-of-string checks, error priority, milliseconds sum, result register.
module tsm_finish (
   input  logic                  clock,
   input  logic                  reset,
   input  tsm_pkg::tsm_snap_type snap,
   output logic                  snap_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_error_code,
   output logic [26:0]           rsp_millis_of_day
);

   typedef struct packed {
      logic [3:0] error;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] millis;
   } tsm_time_type;

   tsm_pkg::tsm_parse_type  st;
   tsm_pkg::tsm_finish_type fin;
   tsm_time_type            chk_ff, chk_in;
   logic                    chk_valid_ff;
   logic [3:0]              sec_error_ff;
   logic [16:0]             seconds_ff, seconds_in;
   logic [9:0]              sec_millis_ff;
   logic                    sec_valid_ff;
   logic [10:0]             minutes;
   logic [26:0]             total_ms;
   logic                    rsp_valid_ff;
   logic [3:0]              rsp_error_ff;
   logic [26:0]             rsp_millis_ff;
   logic                    out_free, sec_free, chk_free;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sec_free   = !sec_valid_ff || out_free;
   assign chk_free   = !chk_valid_ff || sec_free;
   assign snap_stall = !chk_free;

   // close out the string: pending number, missing fields, then range faults
   always_comb begin
      st  = snap.parse;
      fin = tsm_pkg::finish_number(snap.parse);
      chk_in.error = snap.parse.error;
      if (snap.parse.error == tsm_pkg::ERR_NONE) begin
         case (snap.parse.step)
            tsm_pkg::STEP_AWAIT: begin
               chk_in.error = (snap.parse.field == tsm_pkg::FLD_FRACTION) ?
                              tsm_pkg::ERR_NO_FRACTION :
                              tsm_pkg::parse_error(snap.parse.field);
            end
            tsm_pkg::STEP_SIGN: begin
               chk_in.error = tsm_pkg::parse_error(snap.parse.field);
            end
            default: begin
               if (fin.error != tsm_pkg::ERR_NONE) begin
                  chk_in.error = fin.error;
               end else begin
                  st = tsm_pkg::apply_finish(snap.parse, fin);
                  if (snap.parse.field == tsm_pkg::FLD_HOUR) begin
                     chk_in.error = tsm_pkg::ERR_NO_COLON;
                  end
               end
            end
         endcase
      end
      if (chk_in.error == tsm_pkg::ERR_NONE) begin
         if (st.faults[0]) begin
            chk_in.error = tsm_pkg::ERR_HOUR_RANGE;
         end else if (st.faults[1]) begin
            chk_in.error = tsm_pkg::ERR_MINUTE_RANGE;
         end else if (st.faults[2]) begin
            chk_in.error = tsm_pkg::ERR_SECOND_RANGE;
         end else if (st.faults[3]) begin
            chk_in.error = tsm_pkg::ERR_MILLIS_RANGE;
         end
      end
      chk_in.hour   = st.hour;
      chk_in.minute = st.minute;
      chk_in.second = st.second;
      chk_in.millis = st.millis;
   end

   always_comb begin
      minutes    = {6'd0, chk_ff.hour} * 11'd60 + {5'd0, chk_ff.minute};
      seconds_in = {6'd0, minutes} * 17'd60 + {11'd0, chk_ff.second};
      total_ms   = {10'd0, seconds_ff} * 27'd1000 + {17'd0, sec_millis_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (chk_free) chk_valid_ff <= snap.valid;
         if (sec_free) sec_valid_ff <= chk_valid_ff;
         if (out_free) rsp_valid_ff <= sec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (chk_free && snap.valid) begin
         chk_ff <= chk_in;
      end
      if (sec_free && chk_valid_ff) begin
         sec_error_ff  <= chk_ff.error;
         seconds_ff    <= seconds_in;
         sec_millis_ff <= chk_ff.millis;
      end
      if (out_free && sec_valid_ff) begin
         rsp_error_ff  <= sec_error_ff;
         rsp_millis_ff <= (sec_error_ff == tsm_pkg::ERR_NONE) ? total_ms : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_error_code    = rsp_error_ff;
   assign rsp_millis_of_day = rsp_millis_ff;

`ifndef SYNTHESIS
   day_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff == tsm_pkg::ERR_NONE) |-> rsp_millis_ff < tsm_pkg::DAY_MILLIS)
      else $error("result past end of day without error");
`endif

endmodule

@@ sim/time_string_to_millis_tb.sv @@
// Testbench for time_string_to_millis: random and directed strings, checked against a predictor.
`timescale 1ns / 100ps

module time_string_to_millis_tb;

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD = 400;
   localparam int END_SETTLE = 12;
   localparam int REPORT_LIMIT = 10;
   localparam logic [31:0] MS_PER_HOUR = 32'd3_600_000;
   localparam logic [31:0] MS_PER_MINUTE = 32'd60_000;
   localparam logic [31:0] MS_PER_SECOND = 32'd1_000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HALF,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct {
      logic [3:0]  code;
      logic [26:0] millis;
   } parsed_time_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'h00;
   logic        req_last = 1'b0;
   logic        req_empty_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_error_code;
   logic [26:0] rsp_millis_of_day;

   // predictor state for the string being scanned
   logic [1:0]            scan_field;
   tsm_pkg::tsm_step_type scan_step;
   logic                  num_negative;
   logic [31:0]           num_value;
   logic                  num_overflow;
   logic [3:0]            num_digits;
   logic [4:0]            tod_hour;
   logic [5:0]            tod_minute;
   logic [5:0]            tod_second;
   logic [9:0]            tod_millis;
   logic [3:0]            range_flags;
   logic [3:0]            format_error;

   parsed_time_type pending_times[$];
   logic [7:0]      time_text[$];

   int          words_sent = 0;
   int          strings_sent = 0;
   int          results_ok = 0;
   int          results_rejected = 0;
   int          fault_count = 0;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   int          holds_requested = 0;
   bit          steady_stream = 1'b0;
   logic [15:0] codes_seen = '0;

   time_string_to_millis i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .req_last          (req_last),
      .req_empty_req     (req_empty_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_error_code    (rsp_error_code),
      .rsp_millis_of_day (rsp_millis_of_day)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_number();
      num_negative = 1'b0;
      num_value = '0;
      num_overflow = 1'b0;
      num_digits = '0;
   endfunction

   function automatic void clear_scan();
      scan_field = tsm_pkg::FLD_HOUR;
      scan_step = tsm_pkg::STEP_AWAIT;
      clear_number();
      tod_hour = '0;
      tod_minute = '0;
      tod_second = '0;
      tod_millis = '0;
      range_flags = '0;
      format_error = tsm_pkg::ERR_NONE;
   endfunction

   function automatic logic [3:0] field_parse_error(input logic [1:0] fld);
      case (fld)
         tsm_pkg::FLD_HOUR:   return tsm_pkg::ERR_HOUR_PARSE;
         tsm_pkg::FLD_MINUTE: return tsm_pkg::ERR_MINUTE_PARSE;
         tsm_pkg::FLD_SECOND: return tsm_pkg::ERR_SECOND_PARSE;
         default:             return tsm_pkg::ERR_FRACTION_PARSE;
      endcase
   endfunction

   // End the current number; store it or flag its range, return a format error.
   function automatic logic [3:0] close_number();
      logic [31:0] limit;
      logic [31:0] scaled;
      logic [31:0] bound;
      int          chars;
      int          i;
      limit = num_negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (num_overflow || num_value > limit) return field_parse_error(scan_field);
      if (scan_field == tsm_pkg::FLD_FRACTION) begin
         // the sign takes one of the three fraction places
         chars = int'(num_digits) + int'(num_negative);
         if (chars > 3) return tsm_pkg::ERR_FRACTION_LONG;
         scaled = num_value;
         for (i = chars; i < 3; i++) scaled = scaled * 32'd10;
         if (num_negative && scaled != 0) range_flags[3] = 1'b1;
         else tod_millis = scaled[9:0];
      end else begin
         bound = (scan_field == tsm_pkg::FLD_HOUR) ? tsm_pkg::HOUR_BOUND
                                                   : tsm_pkg::SIXTY_BOUND;
         if ((num_negative && num_value != 0) || num_value >= bound) begin
            range_flags[scan_field] = 1'b1;
         end else begin
            case (scan_field)
               tsm_pkg::FLD_HOUR:   tod_hour = num_value[4:0];
               tsm_pkg::FLD_MINUTE: tod_minute = num_value[5:0];
               default:             tod_second = num_value[5:0];
            endcase
         end
      end
      clear_number();
      return tsm_pkg::ERR_NONE;
   endfunction

   function automatic void scan_char(input logic [7:0] ch);
      logic [35:0] grown;
      logic [3:0]  closing;
      if (ch >= tsm_pkg::CHAR_ZERO && ch <= tsm_pkg::CHAR_NINE) begin
         grown = num_value * 36'd10 + 36'(ch - tsm_pkg::CHAR_ZERO);
         if (grown[35:32] != 0) begin
            num_overflow = 1'b1;
            num_value = '1;
         end else begin
            num_value = grown[31:0];
         end
         if (num_digits != 4'd15) num_digits = num_digits + 4'd1;
         scan_step = tsm_pkg::STEP_DIGITS;
      end else if (scan_step == tsm_pkg::STEP_AWAIT && ch == tsm_pkg::CHAR_MINUS) begin
         num_negative = 1'b1;
         scan_step = tsm_pkg::STEP_SIGN;
      end else if (scan_step != tsm_pkg::STEP_DIGITS) begin
         format_error = field_parse_error(scan_field);
      end else begin
         closing = close_number();
         if (closing != tsm_pkg::ERR_NONE) begin
            format_error = closing;
         end else begin
            case (scan_field)
               tsm_pkg::FLD_HOUR: begin
                  if (ch == tsm_pkg::CHAR_COLON) begin
                     scan_field = tsm_pkg::FLD_MINUTE;
                     scan_step = tsm_pkg::STEP_AWAIT;
                  end else begin
                     format_error = tsm_pkg::ERR_NO_COLON;
                  end
               end
               tsm_pkg::FLD_MINUTE: begin
                  if (ch == tsm_pkg::CHAR_COLON) begin
                     scan_field = tsm_pkg::FLD_SECOND;
                     scan_step = tsm_pkg::STEP_AWAIT;
                  end else begin
                     format_error = tsm_pkg::ERR_TRAILING;
                  end
               end
               tsm_pkg::FLD_SECOND: begin
                  if (ch == tsm_pkg::CHAR_DOT) begin
                     scan_field = tsm_pkg::FLD_FRACTION;
                     scan_step = tsm_pkg::STEP_AWAIT;
                  end else begin
                     format_error = tsm_pkg::ERR_TRAILING;
                  end
               end
               default: format_error = tsm_pkg::ERR_TRAILING;
            endcase
         end
      end
   endfunction

   function automatic void predict_word(input logic [7:0] ch, input logic lst,
                                        input logic emp);
      logic [3:0]      code;
      logic [3:0]      closing;
      logic [31:0]     total_ms;
      parsed_time_type entry;
      if (!emp && format_error == tsm_pkg::ERR_NONE) scan_char(ch);
      if (lst) begin
         if (format_error == tsm_pkg::ERR_NONE) begin
            case (scan_step)
               tsm_pkg::STEP_AWAIT:
                  format_error = (scan_field == tsm_pkg::FLD_FRACTION)
                                 ? tsm_pkg::ERR_NO_FRACTION
                                 : field_parse_error(scan_field);
               tsm_pkg::STEP_SIGN:  format_error = field_parse_error(scan_field);
               default: begin
                  closing = close_number();
                  if (closing == tsm_pkg::ERR_NONE && scan_field == tsm_pkg::FLD_HOUR)
                     closing = tsm_pkg::ERR_NO_COLON;
                  format_error = closing;
               end
            endcase
         end
         code = format_error;
         if (code == tsm_pkg::ERR_NONE) begin
            if (range_flags[0]) code = tsm_pkg::ERR_HOUR_RANGE;
            else if (range_flags[1]) code = tsm_pkg::ERR_MINUTE_RANGE;
            else if (range_flags[2]) code = tsm_pkg::ERR_SECOND_RANGE;
            else if (range_flags[3]) code = tsm_pkg::ERR_MILLIS_RANGE;
         end
         total_ms = '0;
         if (code == tsm_pkg::ERR_NONE) begin
            total_ms = tod_hour * MS_PER_HOUR + tod_minute * MS_PER_MINUTE
                     + tod_second * MS_PER_SECOND + tod_millis;
         end
         entry.code = code;
         entry.millis = total_ms[26:0];
         pending_times.push_back(entry);
         clear_scan();
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_fault(input string what, input int want, input int got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   always @(posedge clock) begin
      parsed_time_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_times.size() == 0) begin
            note_fault("response with no string pending", -1, int'(rsp_error_code));
         end else begin
            want = pending_times.pop_front();
            if (rsp_error_code !== want.code)
               note_fault("error_code", int'(want.code), int'(rsp_error_code));
            if (rsp_millis_of_day !== want.millis)
               note_fault("millis_of_day", int'(want.millis), int'(rsp_millis_of_day));
            codes_seen[want.code] = 1'b1;
            if (want.code == tsm_pkg::ERR_NONE) results_ok++;
            else results_rejected++;
         end
      end
   end

   // end the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d strings pending",
                  quiet_cycles, pending_times.size());
         $display("time_string_to_millis_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response back-pressure: random modes, plus long holds on request
   always @(posedge clock) begin
      static stall_mode_type stall_mode = STALL_NONE;
      static int mode_left = 0;
      static int hold_left = 0;
      static int holds_started = 0;
      if (holds_started != holds_requested) begin
         hold_left = LONG_HOLD;
         holds_started++;
      end
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(32, 256);
      end else begin
         mode_left--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
            default:     rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(8, 64);
         if (!steady_stream && $urandom_range(0, 4) != 0) idle_sender($urandom_range(1, 8));
      end
   endtask

   task automatic send_word(input logic [7:0] ch, input logic lst, input logic emp);
      req_valid <= 1'b1;
      req_character <= ch;
      req_last <= lst;
      req_empty_req <= emp;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_word(ch, lst, emp);
      words_sent++;
      if (lst) strings_sent++;
      pace_sender();
   endtask

   // Send time_text, with stray empty words; end on an empty word if asked or if the text is empty.
   task automatic send_text(input bit empty_tail);
      int n;
      n = time_text.size();
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 15) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         send_word(time_text[k], (k == n - 1) && !empty_tail, 1'b0);
      end
      if (empty_tail || n == 0) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
   endtask

   task automatic send_literal(input string s);
      time_text.delete();
      for (int k = 0; k < s.len(); k++) time_text.push_back(s[k]);
      send_text(1'b0);
   endtask

   task automatic wait_for_results();
      idle_sender(1);
      while (pending_times.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- strings

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return tsm_pkg::CHAR_COLON;
         1:       return tsm_pkg::CHAR_DOT;
         2:       return tsm_pkg::CHAR_MINUS;
         3:       return tsm_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
         4:       return 8'h20;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void push_digits(input int count);
      repeat (count) time_text.push_back(tsm_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void push_decimal(input longint unsigned value, input int zeros);
      string digits;
      digits = $sformatf("%0d", value);
      repeat (zeros) time_text.push_back(tsm_pkg::CHAR_ZERO);
      for (int k = 0; k < digits.len(); k++) time_text.push_back(digits[k]);
   endfunction

   // One number, at times signed or empty: mostly in range, some past the bound, near 32 bits, or huge.
   function automatic void add_number(input int bound, input bit fraction);
      int pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 12) time_text.push_back(tsm_pkg::CHAR_MINUS);
      if (pick < 6) begin
         return;
      end else if (pick < 70) begin
         if (fraction) push_digits($urandom_range(1, 3));
         else push_decimal($urandom_range(0, bound - 1),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
      end else if (pick < 82) begin
         if (fraction) push_digits($urandom_range(4, 7));
         else push_decimal(bound + $urandom_range(0, 60), 0);
      end else if (pick < 92) begin
         case ($urandom_range(0, 4))
            0:       push_decimal(64'd2147483647, 0);
            1:       push_decimal(64'd2147483648, 0);
            2:       push_decimal(64'd4294967295, 0);
            3:       push_decimal(64'd4294967296, 0);
            default: push_decimal($urandom, 0);
         endcase
      end else begin
         push_digits($urandom_range(11, 14));
      end
   endfunction

   function automatic void build_time_string();
      int spot;
      time_text.delete();
      if ($urandom_range(0, 99) < 4) begin
         repeat ($urandom_range(0, 10)) time_text.push_back(pick_byte());
         return;
      end
      add_number(24, 1'b0);
      time_text.push_back(tsm_pkg::CHAR_COLON);
      add_number(60, 1'b0);
      if ($urandom_range(0, 99) < 70) begin
         time_text.push_back(tsm_pkg::CHAR_COLON);
         add_number(60, 1'b0);
         if ($urandom_range(0, 99) < 65) begin
            time_text.push_back(tsm_pkg::CHAR_DOT);
            add_number(1000, 1'b1);
         end
      end
      // damage a few well-formed strings
      if ($urandom_range(0, 99) < 15) begin
         spot = $urandom_range(0, time_text.size() - 1);
         case ($urandom_range(0, 3))
            0:       time_text[spot] = pick_byte();
            1:       time_text.insert(spot, pick_byte());
            2:       while (time_text.size() > spot) void'(time_text.pop_back());
            default: time_text.push_back(pick_byte());
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_strings();
      send_literal("");
      send_literal("23:59:59.999");
      send_literal("-0:-0");
      send_literal("0:0:0.-5");
      send_literal("1:2:3.1234");
      send_word(8'hFF, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b0);
      wait_for_results();
   endtask

   task automatic test_random_strings(input int word_goal);
      int stop_at;
      stop_at = words_sent + word_goal;
      while (words_sent < stop_at) begin
         build_time_string();
         send_text($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 39) == 0) wait_for_results();
      end
   endtask

   // hold responses off while words keep coming, so the input side backs up
   task automatic test_input_backpressure();
      int stop_at;
      stop_at = words_sent + 100;
      holds_requested++;
      steady_stream = 1'b1;
      while (words_sent < stop_at) begin
         build_time_string();
         send_text(1'b0);
      end
      steady_stream = 1'b0;
      wait_for_results();
   endtask

   task automatic test_steady_stream(input int word_goal);
      steady_stream = 1'b1;
      test_random_strings(word_goal);
      steady_stream = 1'b0;
      wait_for_results();
   endtask

   initial begin
      clear_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_strings();
      test_random_strings(650);
      test_input_backpressure();
      test_steady_stream(750);
      wait_for_results();
      repeat (END_SETTLE) @(posedge clock);
      if (pending_times.size() != 0)
         note_fault("strings left without a response", 0, pending_times.size());
      $display("sent %0d words in %0d strings; %0d times parsed, %0d strings rejected",
               words_sent, strings_sent, results_ok, results_rejected);
      $display("error codes returned (bit per code): %b, faults: %0d", codes_seen, fault_count);
      if (fault_count == 0) begin
         $display("time_string_to_millis_tb: clean");
      end else begin
         $display("time_string_to_millis_tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tsm_pkg.sv
rtl/tsm_front.sv
rtl/tsm_queue.sv
rtl/tsm_engine.sv
rtl/tsm_finish.sv
rtl/time_string_to_millis.sv
sim/time_string_to_millis_tb.sv
